// ----- design/nsrc_pkg.sv -----
`timescale 1ns / 1ps

package nsrc_pkg;

  // sizes of the converter
  localparam int HistoryDepth = 16;
  localparam int MaxUpsample  = 8;

  localparam int SampleW  = 16;
  localparam int RateW    = 19;
  localparam int RemW     = RateW + 1;
  localparam int ProdW    = RateW + 8;
  localparam int SlotW    = $clog2(HistoryDepth);
  localparam int CountW   = $clog2(MaxUpsample + 1);
  localparam int OpW      = 2;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 1;

  localparam logic [RateW-1:0] RateReset = RateW'(16000);

  typedef enum logic [OpW-1:0] {
    OpPush    = 2'd0,
    OpFlush   = 2'd1,
    OpRestart = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StSample = 2'd0,
    StAck    = 2'd1,
    StReject = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcRate = 1'b0,
    CfgDstRate = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic    push;
    logic    set_finished;
    logic    clear;
    logic    check;
    logic    step;
    logic    load_sample;
    logic    load_status;
    logic    last;
    status_e status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic valid_pair;
    logic finished;
    logic due;
    logic more_due;
    logic step_needed;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- design/nsrc_if.sv -----
`timescale 1ns / 1ps

interface nsrc_in_if;
  logic                                valid;
  logic                                ready;
  logic [nsrc_pkg::OpW-1:0]            opcode;
  logic signed [nsrc_pkg::SampleW-1:0] sample_in;

  modport source (output valid, output opcode, output sample_in, input ready);
  modport sink   (input valid, input opcode, input sample_in, output ready);
endinterface

interface nsrc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nsrc_pkg::SampleW-1:0] sample_out;
  logic [nsrc_pkg::StatusW-1:0]        status;
  logic                                last;

  modport source (output valid, output sample_out, output status, output last, input ready);
  modport sink   (input valid, input sample_out, input status, input last, output ready);
endinterface

interface nsrc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nsrc_pkg::CfgIdxW-1:0]     index;
  logic [nsrc_pkg::RateW-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/nearest_sample_rate_converter.sv -----
`timescale 1ns / 1ps

// channel  | dir | handshake     | payload
// in_i     | in  | valid / ready | opcode[1:0], sample_in[15:0] signed
// out_o    | out | valid / ready | sample_out[15:0] signed, status[1:0], last
// cfg_i    | in  | valid / ready | index[0] (0 source rate, 1 destination rate), data[18:0]
//
// one item at a time: a push is taken in Idle, then each output it owes passes Check, Emit
// and Step, where the source index advances (up to 15 steps, set by the src/dst ratio);
// a push owing no output leaves Check for Idle; flush, restart and rejected items use Resp
// a stalled output register holds the controller in place; no input taken meanwhile
// reset clears counters and the finished flag, rates return to 16000
// history entries hold no reset value and are always written before read
module nearest_sample_rate_converter (
  input logic        clk_i,
  input logic        rst_ni,
  nsrc_in_if.sink    in_i,
  nsrc_out_if.source out_o,
  nsrc_cfg_if.sink   cfg_i
);

  // command and status between sequencer and datapath
  nsrc_pkg::dp_cmd_t cmd;
  nsrc_pkg::dp_sts_t sts;

  // sequencer: decodes opcodes, walks the output loop and the index steps
  nsrc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath: rate registers, remainder accumulators, history ring, output register
  nsrc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .sample_i (in_i.sample_in),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_o    (out_o)
  );

endmodule

// ----- design/nsrc_ctrl.sv -----
`timescale 1ns / 1ps

module nsrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  nsrc_in_if.sink           in_i,
  input  nsrc_pkg::dp_sts_t sts_i,
  output nsrc_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    Idle,
    Check,
    Emit,
    Step,
    Resp
  } state_e;

  state_e                          state_q;
  logic [nsrc_pkg::CountW-1:0]     n_q;
  logic                            last_q;
  nsrc_pkg::status_e               resp_q;

  logic accept;
  logic push_ok;
  logic flush_ok;
  logic restart_ok;
  logic cap_hit;

  assign in_i.ready = (state_q == Idle);
  assign accept     = in_i.valid && in_i.ready;

  assign push_ok    = (in_i.opcode == nsrc_pkg::OpPush) && sts_i.valid_pair && !sts_i.finished;
  assign flush_ok   = (in_i.opcode == nsrc_pkg::OpFlush) && sts_i.valid_pair &&
                      !sts_i.finished;
  assign restart_ok = (in_i.opcode == nsrc_pkg::OpRestart) && sts_i.valid_pair;
  assign cap_hit    = (n_q == nsrc_pkg::CountW'(nsrc_pkg::MaxUpsample - 1));

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = resp_q;
    cmd_o.last   = last_q;
    unique case (state_q)
      Idle: begin
        cmd_o.push         = accept && push_ok;
        cmd_o.set_finished = accept && flush_ok;
        cmd_o.clear        = accept && restart_ok;
      end
      Check: cmd_o.check       = sts_i.due;
      Emit:  cmd_o.load_sample = sts_i.out_free;
      Step:  cmd_o.step        = sts_i.step_needed;
      Resp:  cmd_o.load_status = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      n_q     <= '0;
      last_q  <= 1'b0;
      resp_q  <= nsrc_pkg::StReject;
    end else begin
      unique case (state_q)
        Idle: begin
          if (accept) begin
            n_q <= '0;
            if (push_ok) begin
              state_q <= Check;
            end else begin
              resp_q  <= (flush_ok || restart_ok) ? nsrc_pkg::StAck : nsrc_pkg::StReject;
              state_q <= Resp;
            end
          end
        end
        Check: begin
          if (sts_i.due) begin
            last_q  <= !sts_i.more_due || cap_hit;
            state_q <= Emit;
          end else begin
            state_q <= Idle;
          end
        end
        Emit: begin
          if (sts_i.out_free) begin
            n_q     <= n_q + 1'b1;
            state_q <= Step;
          end
        end
        Step: begin
          if (!sts_i.step_needed) begin
            state_q <= last_q ? Idle : Check;
          end
        end
        Resp: begin
          if (sts_i.out_free) begin
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // once a sample is out without last, another one must be due
  a_due_after_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Check && !sts_i.due) |-> (n_q == '0))
    else $error("no output due after a non-final sample");

  // a push never runs past the upsample limit
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Emit) |-> (n_q < nsrc_pkg::CountW'(nsrc_pkg::MaxUpsample)))
    else $error("too many outputs for one push");

endmodule

// ----- design/nsrc_dp.sv -----
`timescale 1ns / 1ps

module nsrc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  nsrc_cfg_if.sink                            cfg_i,
  input  logic signed [nsrc_pkg::SampleW-1:0] sample_i,
  input  nsrc_pkg::dp_cmd_t                   cmd_i,
  output nsrc_pkg::dp_sts_t                   sts_o,
  nsrc_out_if.source                          out_o
);

  logic [nsrc_pkg::RateW-1:0]   src_q;
  logic [nsrc_pkg::RateW-1:0]   dst_q;
  logic [nsrc_pkg::SlotW-1:0]   wslot_q;
  logic [nsrc_pkg::SlotW-1:0]   sslot_q;
  logic [nsrc_pkg::RemW-1:0]    crem_q;
  logic [nsrc_pkg::RemW-1:0]    irem_q;
  logic                         fin_q;

  logic [nsrc_pkg::SampleW-1:0] hist_mem [nsrc_pkg::HistoryDepth];
  logic [nsrc_pkg::SampleW-1:0] rd_q;

  logic                         out_valid_q;
  logic [nsrc_pkg::SampleW-1:0] out_sample_q;
  logic [nsrc_pkg::StatusW-1:0] out_status_q;
  logic                         out_last_q;

  logic                         cfg_we;
  logic [nsrc_pkg::RemW-1:0]    src_w;
  logic [nsrc_pkg::RemW-1:0]    dst_w;
  logic [nsrc_pkg::ProdW-1:0]   src_max;
  logic [nsrc_pkg::ProdW-1:0]   dst_max;

  function automatic logic [nsrc_pkg::SlotW-1:0] next_slot(
    input logic [nsrc_pkg::SlotW-1:0] s
  );
    return (s == nsrc_pkg::SlotW'(nsrc_pkg::HistoryDepth - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  assign src_w   = nsrc_pkg::RemW'(src_q);
  assign dst_w   = nsrc_pkg::RemW'(dst_q);
  assign src_max = nsrc_pkg::ProdW'(src_q) * nsrc_pkg::ProdW'(nsrc_pkg::MaxUpsample);
  assign dst_max = nsrc_pkg::ProdW'(dst_q) * nsrc_pkg::ProdW'(nsrc_pkg::HistoryDepth - 1);

  assign sts_o.valid_pair  = (src_q != '0) && (dst_q != '0) &&
                             (nsrc_pkg::ProdW'(dst_q) <= src_max) &&
                             (nsrc_pkg::ProdW'(src_q) <= dst_max);
  assign sts_o.finished    = fin_q;
  assign sts_o.due         = (crem_q >= src_w);
  assign sts_o.more_due    = ({1'b0, crem_q} >= {src_w, 1'b0});
  assign sts_o.step_needed = (irem_q >= dst_w);
  assign sts_o.out_free    = !out_valid_q || out_o.ready;

  // counters and rate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= nsrc_pkg::RateReset;
      dst_q   <= nsrc_pkg::RateReset;
      wslot_q <= '0;
      sslot_q <= '0;
      crem_q  <= '0;
      irem_q  <= '0;
      fin_q   <= 1'b0;
    end else if (cfg_we || cmd_i.clear) begin
      if (cfg_we) begin
        unique case (nsrc_pkg::cfg_idx_e'(cfg_i.index))
          nsrc_pkg::CfgSrcRate: src_q <= cfg_i.data;
          nsrc_pkg::CfgDstRate: dst_q <= cfg_i.data;
          default: ;
        endcase
      end
      wslot_q <= '0;
      sslot_q <= '0;
      crem_q  <= '0;
      irem_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      if (cmd_i.set_finished) begin
        fin_q <= 1'b1;
      end
      if (cmd_i.push) begin
        wslot_q <= next_slot(wslot_q);
        crem_q  <= crem_q + dst_w;
      end
      if (cmd_i.check) begin
        crem_q <= crem_q - src_w;
        irem_q <= irem_q + src_w;
      end
      if (cmd_i.step) begin
        irem_q  <= irem_q - dst_w;
        sslot_q <= next_slot(sslot_q);
      end
    end
  end

  // history ring, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hist_mem[wslot_q] <= sample_i;
    end
    if (cmd_i.check) begin
      rd_q <= hist_mem[sslot_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_sample || cmd_i.load_status) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      out_sample_q <= rd_q;
      out_status_q <= nsrc_pkg::StSample;
      out_last_q   <= cmd_i.last;
    end else if (cmd_i.load_status) begin
      out_sample_q <= '0;
      out_status_q <= cmd_i.status;
      out_last_q   <= 1'b1;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_sample || cmd_i.load_status) |-> (!out_valid_q || out_o.ready))
    else $error("output register overwritten");

  // output remainder stays below src + dst for a usable rate pair
  a_crem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.valid_pair |-> (crem_q < src_w + dst_w))
    else $error("count remainder out of range");

  // source remainder stays below src + dst for a usable rate pair
  a_irem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.valid_pair |-> (irem_q < src_w + dst_w))
    else $error("index remainder out of range");

endmodule

// ----- tb/nearest_sample_rate_converter_tb.sv -----
`timescale 1ns / 1ps

// checks the rate converter against a cycle-free predictor kept in this module:
// every transfer on the input channel is replayed through the predictor, which
// queues the outputs it owes; every transfer on the output channel is checked
// against the oldest queued output, field by field
module nearest_sample_rate_converter_tb;

  // opcode three has no name in the package, the block must reject it
  localparam logic [nsrc_pkg::OpW-1:0] OpUnused = 2'd3;

  localparam int SettleCycles = 32;   // covers a push that owes no output
  localparam int HoldCycles   = 250;  // long output stall for the fill test
  localparam int PhaseItems   = 20;
  localparam int NumPhases    = 10;

  // idle percentages: one side alone, both sides together
  localparam int SoloPct  = 64;
  localparam int MixedPct = 38;

  typedef struct packed {
    logic [nsrc_pkg::SampleW-1:0] sample;
    nsrc_pkg::status_e            status;
    logic                         last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nsrc_in_if  in_ch ();
  nsrc_out_if out_ch ();
  nsrc_cfg_if cfg_ch ();

  nearest_sample_rate_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [nsrc_pkg::RateW-1:0]   src_hz;
  logic [nsrc_pkg::RateW-1:0]   dst_hz;
  logic [nsrc_pkg::SampleW-1:0] ring [nsrc_pkg::HistoryDepth];
  logic [nsrc_pkg::SlotW-1:0]   wr_slot;
  logic [nsrc_pkg::SlotW-1:0]   rd_slot;
  logic [nsrc_pkg::RemW-1:0]    due_acc;   // outputs owed, in units of src_hz
  logic [nsrc_pkg::RemW-1:0]    step_acc;  // source index progress, in units of dst_hz
  logic                         stream_done;

  result_t pending_outputs[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_armed   = 1'b0;
  int held_cycles    = 0;

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  function automatic void clear_counters();
    for (int i = 0; i < nsrc_pkg::HistoryDepth; i++) ring[i] = '0;
    wr_slot     = '0;
    rd_slot     = '0;
    due_acc     = '0;
    step_acc    = '0;
    stream_done = 1'b0;
  endfunction

  function automatic logic [nsrc_pkg::SlotW-1:0] bump_slot(logic [nsrc_pkg::SlotW-1:0] s);
    return (s == nsrc_pkg::SlotW'(nsrc_pkg::HistoryDepth - 1)) ? '0 : s + 1'b1;
  endfunction

  // both rates set, upsampling within MaxUpsample, downsampling within the ring
  function automatic bit rates_ok();
    int unsigned s;
    int unsigned d;
    s = src_hz;
    d = dst_hz;
    return s != 0 && d != 0 && d <= nsrc_pkg::MaxUpsample * s &&
           s <= (nsrc_pkg::HistoryDepth - 1) * d;
  endfunction

  // append one owed result at the tail of the queue
  function automatic void queue_result(result_t r);
    pending_outputs.insert(pending_outputs.size(), r);
  endfunction

  function automatic void owe_single(nsrc_pkg::status_e st);
    queue_result('{sample: '0, status: st, last: 1'b1});
  endfunction

  function automatic void resample_item(logic [nsrc_pkg::OpW-1:0] op,
                                        logic [nsrc_pkg::SampleW-1:0] smp);
    bit ok;
    int n;
    ok = rates_ok();
    n = 0;
    case (op)
      nsrc_pkg::OpFlush: begin
        if (!ok || stream_done) begin
          owe_single(nsrc_pkg::StReject);
        end else begin
          stream_done = 1'b1;
          owe_single(nsrc_pkg::StAck);
        end
      end
      nsrc_pkg::OpRestart: begin
        if (!ok) begin
          owe_single(nsrc_pkg::StReject);
        end else begin
          clear_counters();
          owe_single(nsrc_pkg::StAck);
        end
      end
      nsrc_pkg::OpPush: begin
        if (!ok || stream_done) begin
          owe_single(nsrc_pkg::StReject);
        end else begin
          ring[wr_slot] = smp;
          wr_slot = bump_slot(wr_slot);
          due_acc = due_acc + dst_hz;
          while (due_acc >= src_hz && n < nsrc_pkg::MaxUpsample) begin
            due_acc = due_acc - src_hz;
            queue_result('{sample: ring[rd_slot], status: nsrc_pkg::StSample, last: 1'b0});
            n++;
            step_acc = step_acc + src_hz;
            while (step_acc >= dst_hz) begin
              step_acc = step_acc - dst_hz;
              rd_slot = bump_slot(rd_slot);
            end
          end
          if (n > 0) pending_outputs[pending_outputs.size() - 1].last = 1'b1;
        end
      end
      default: begin
        owe_single(nsrc_pkg::StReject);
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // output side: ready pattern and result checks
  // ------------------------------------------------------------------

  // ready follows the stall rate, except while a long hold is armed,
  // which is counted here so the sender can keep offering meanwhile
  always @(posedge clk_i) begin
    if (hold_armed && held_cycles < HoldCycles) begin
      out_ch.ready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_armed) held_cycles <= 0;
    end
  end

  // every output transfer must match the oldest owed result
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected transfer: sample_out %0d, status %0d, last %0d",
               $signed(out_ch.sample_out), out_ch.status, out_ch.last);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.sample_out !== want.sample) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 $signed(want.sample), $signed(out_ch.sample_out));
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------

  // random gap after a transfer; valid drops only when a gap is taken
  task automatic pace_sender();
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // offer one item, wait for its transfer, then let the predictor see it
  task automatic send_item(input logic [nsrc_pkg::OpW-1:0] op,
                           input logic [nsrc_pkg::SampleW-1:0] smp);
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.sample_in <= smp;
    do @(posedge clk_i); while (!in_ch.ready);
    resample_item(op, smp);
    pace_sender();
  endtask

  task automatic push_random();
    send_item(nsrc_pkg::OpPush, nsrc_pkg::SampleW'($urandom()));
  endtask

  // stop offering, wait for every owed output, then let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // both rate registers back to back, only while the block is idle;
  // each write also clears the counters
  task automatic program_rates(input logic [nsrc_pkg::RateW-1:0] src,
                               input logic [nsrc_pkg::RateW-1:0] dst);
    wait_idle();
    for (int i = 0; i < 2; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= (i == 0) ? nsrc_pkg::CfgSrcRate : nsrc_pkg::CfgDstRate;
      cfg_ch.data  <= (i == 0) ? src : dst;
      do @(posedge clk_i); while (!cfg_ch.ready);
      if (i == 0) src_hz = src;
      else dst_hz = dst;
      clear_counters();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // idling phases: none, sender only, receiver only, both
  function automatic void set_idling(int setting);
    case (setting)
      1: begin
        send_idle_pct  = SoloPct;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = SoloPct;
      end
      3: begin
        send_idle_pct  = MixedPct;
        recv_stall_pct = MixedPct;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset rates are 16000 / 16000: one output per push
  task automatic test_commands();
    set_idling(0);
    send_item(nsrc_pkg::OpPush, 16'h7FFF);      // most positive sample
    send_item(nsrc_pkg::OpPush, 16'h8000);      // most negative sample
    send_item(nsrc_pkg::OpPush, 16'h0000);
    send_item(nsrc_pkg::OpPush, 16'hFFFF);
    send_item(OpUnused, 16'h1234);              // unused opcode is rejected
    send_item(nsrc_pkg::OpFlush, 16'h0);        // end of stream acknowledged
    send_item(nsrc_pkg::OpPush, 16'h5555);      // push after flush is rejected
    send_item(nsrc_pkg::OpFlush, 16'h0);        // second flush is rejected
    send_item(nsrc_pkg::OpRestart, 16'h0);      // restart clears the finished flag
    send_item(nsrc_pkg::OpPush, 16'hAAAA);
  endtask

  // invalid rate pairs reject every opcode; extremes of the valid range
  task automatic test_rate_limits();
    set_idling(3);
    program_rates(19'd0, 19'd16000);        // zero source rate
    send_item(nsrc_pkg::OpPush, 16'h0101);
    send_item(nsrc_pkg::OpFlush, 16'h0);
    send_item(nsrc_pkg::OpRestart, 16'h0);
    program_rates(19'd16000, 19'd0);        // zero destination rate
    send_item(nsrc_pkg::OpPush, 16'h0202);
    program_rates(19'd1000, 19'd8001);      // one past the upsampling limit
    send_item(nsrc_pkg::OpPush, 16'h0303);
    program_rates(19'd15001, 19'd1000);     // one past the downsampling limit
    send_item(nsrc_pkg::OpPush, 16'h0404);
    program_rates(19'd384000, 19'd384000);  // top of both ranges
    send_item(nsrc_pkg::OpPush, 16'h0505);
    program_rates(19'd1, 19'd8);            // full upsampling, eight outputs per push
    push_random();
    push_random();
  endtask

  // output held off while the sender keeps offering 8x upsampled pushes,
  // so the block fills and stalls its input; then the receiver drains it
  task automatic test_output_stall();
    set_idling(0);
    program_rates(19'd48000, 19'd384000);
    hold_armed <= 1'b1;
    repeat (12) push_random();
    wait_idle();
    hold_armed <= 1'b0;
    @(posedge clk_i);
  endtask

  // random content in phases of different rates and idling
  task automatic test_random_stream();
    logic [nsrc_pkg::RateW-1:0] src;
    logic [nsrc_pkg::RateW-1:0] dst;
    int unsigned lo;
    int unsigned hi;
    int left;
    int pick;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin src = 19'd44100;  dst = 19'd48000;  end
        1: begin src = 19'd48000;  dst = 19'd44100;  end
        2: begin src = 19'd384000; dst = 19'd25600;  end  // deepest downsampling
        3: begin src = 19'd15;     dst = 19'd1;      end
        4: begin src = 19'd1;      dst = 19'd8;      end
        5: begin src = 19'd384000; dst = 19'd384000; end
        default: begin
          src = nsrc_pkg::RateW'($urandom_range(1, 384000));
          lo  = (src + 14) / 15;
          hi  = (8 * src > 384000) ? 384000 : 8 * src;
          dst = nsrc_pkg::RateW'($urandom_range(lo, hi));
        end
      endcase
      program_rates(src, dst);
      set_idling(p % 4);
      left = PhaseItems;
      while (left > 0) begin
        pick = $urandom_range(99);
        if (pick < 84) begin
          push_random();
          left--;
        end else if (pick < 90) begin
          // end of stream, a late push, then a fresh start
          send_item(nsrc_pkg::OpFlush, nsrc_pkg::SampleW'($urandom()));
          push_random();
          send_item(nsrc_pkg::OpRestart, nsrc_pkg::SampleW'($urandom()));
          left -= 3;
        end else if (pick < 97) begin
          send_item(nsrc_pkg::OpRestart, nsrc_pkg::SampleW'($urandom()));
          left--;
        end else begin
          send_item(OpUnused, nsrc_pkg::SampleW'($urandom()));
          left--;
        end
      end
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.opcode     = nsrc_pkg::OpPush;
    in_ch.sample_in  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = nsrc_pkg::CfgSrcRate;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    src_hz = nsrc_pkg::RateReset;
    dst_hz = nsrc_pkg::RateReset;
    clear_counters();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_rate_limits();
    test_output_stall();
    test_random_stream();

    set_idling(0);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
